// File: design/qptd_pkg.sv
// ----------------------------------------------------------------------------
// qptd_pkg: shared types and constants for the pulse train doser
// Field widths, register reset values, register indexes and the drive
// status structure used between the drive engine and the top level.
// ----------------------------------------------------------------------------
package qptd_pkg;

    localparam int AMOUNT_W  = 10;
    localparam int TARGET_W  = 14;
    localparam int TIMER_W   = 17;
    localparam int TOTAL_W   = 32;
    localparam int FED_W     = 29;
    localparam int QJOBS_W   = 4;
    localparam int TICKS_W   = 16;
    localparam int MAXP_W    = 10;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam int RING_DEPTH_DEF    = 8;
    localparam int PULSES_PER_ML_DEF = 8;

    localparam logic [TICKS_W-1:0] HIGH_TICKS_RST = 16'd2000;
    localparam logic [TICKS_W-1:0] LOW_TICKS_RST  = 16'd20000;
    localparam logic [MAXP_W-1:0]  MAX_PULSES_RST = 10'd800;

    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_TICKS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PULSES = 2'd2;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_FEED = 1'b1;

    typedef struct packed {
        logic             pin;
        logic             done;
        logic [FED_W-1:0] fed_ml;
    } t_drive_out;

endpackage

// File: design/qptd_req_if.sv
// ----------------------------------------------------------------------------
// qptd_req_if: request channel into the doser
// Carries the operation code and the feed amount with a valid/ready pair.
// ----------------------------------------------------------------------------
interface qptd_req_if
    import qptd_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                op;
    logic [AMOUNT_W-1:0] amount_ml;

    modport source (output valid, output op, output amount_ml, input ready);
    modport sink   (input valid, input op, input amount_ml, output ready);
endinterface

// File: design/qptd_res_if.sv
// ----------------------------------------------------------------------------
// qptd_res_if: result channel out of the doser
// Carries one result per request with a valid/ready pair.
// ----------------------------------------------------------------------------
interface qptd_res_if
    import qptd_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               drive_level;
    logic               request_accepted;
    logic               request_rejected;
    logic               job_done;
    logic [FED_W-1:0]   fed_total_ml;
    logic [QJOBS_W-1:0] queued_jobs;

    modport source (output valid, output drive_level, output request_accepted,
                    output request_rejected, output job_done, output fed_total_ml,
                    output queued_jobs, input ready);
    modport sink   (input valid, input drive_level, input request_accepted,
                    input request_rejected, input job_done, input fed_total_ml,
                    input queued_jobs, output ready);
endinterface

// File: design/qptd_ram.sv
// ----------------------------------------------------------------------------
// qptd_ram: generic single write port RAM with a registered read
// One write and one read address per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module qptd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: design/qptd_drive.sv
// ----------------------------------------------------------------------------
// qptd_drive: pulse drive engine
// Runs the low/high phase timer, counts pulses for the current job and keeps
// the running pulse total together with its quotient by the pulse scale.
// ----------------------------------------------------------------------------
module qptd_drive
    import qptd_pkg::*;
#(
    parameter int PULSES_PER_ML = PULSES_PER_ML_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_tick,
    input  logic                i_ring_busy,
    input  logic [TARGET_W-1:0] i_target,
    input  logic [TICKS_W-1:0]  i_high_ticks,
    input  logic [TICKS_W-1:0]  i_low_ticks,
    input  logic [MAXP_W-1:0]   i_max_pulses,
    output t_drive_out          o_status
);
    localparam int REM_W = (PULSES_PER_ML > 1) ? $clog2(PULSES_PER_ML) : 1;
    localparam logic [REM_W-1:0] REM_LAST = REM_W'(PULSES_PER_ML - 1);

    logic                r_active, n_active;
    logic                r_pin, n_pin;
    logic [TARGET_W-1:0] r_count, n_count;
    logic [TIMER_W-1:0]  r_timer, n_timer;
    logic [TOTAL_W-1:0]  r_total, n_total;
    logic [FED_W-1:0]    r_quot, n_quot;
    logic [REM_W-1:0]    r_rem, n_rem;
    logic                done;
    logic [TIMER_W-1:0]  timer_inc;
    logic [TARGET_W-1:0] count_inc;

    always_comb begin
        n_active  = r_active;
        n_pin     = r_pin;
        n_count   = r_count;
        n_timer   = r_timer;
        n_total   = r_total;
        n_quot    = r_quot;
        n_rem     = r_rem;
        done      = 1'b0;
        timer_inc = (r_timer == {TIMER_W{1'b1}}) ? r_timer : r_timer + 1'b1;
        count_inc = r_count + 1'b1;

        if (i_tick) begin
            if (r_active) begin
                n_timer = timer_inc;
                if (!r_pin) begin
                    if (timer_inc > {1'b0, i_low_ticks}) begin
                        // Count the pulse; the quotient follows the total so
                        // no divider is needed, and restarts when it wraps.
                        n_total = r_total + 1'b1;
                        n_count = count_inc;
                        if (n_total == '0) begin
                            n_quot = '0;
                            n_rem  = '0;
                        end else if (r_rem == REM_LAST) begin
                            n_quot = r_quot + 1'b1;
                            n_rem  = '0;
                        end else begin
                            n_rem = r_rem + 1'b1;
                        end
                        if (count_inc > i_target
                                || count_inc > TARGET_W'(i_max_pulses)) begin
                            n_active = 1'b0;
                            done     = 1'b1;
                        end else begin
                            n_pin   = 1'b1;
                            n_timer = '0;
                        end
                    end
                end else if (timer_inc > {1'b0, i_high_ticks}) begin
                    n_pin   = 1'b0;
                    n_timer = '0;
                end
            end else if (i_ring_busy) begin
                n_active = 1'b1;
                n_count  = '0;
                n_pin    = 1'b0;
                n_timer  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_pin    <= 1'b0;
            r_count  <= '0;
            r_timer  <= '0;
            r_total  <= '0;
            r_quot   <= '0;
            r_rem    <= '0;
        end else begin
            r_active <= n_active;
            r_pin    <= n_pin;
            r_count  <= n_count;
            r_timer  <= n_timer;
            r_total  <= n_total;
            r_quot   <= n_quot;
            r_rem    <= n_rem;
        end
    end

    assign o_status.pin    = n_pin;
    assign o_status.done   = done;
    assign o_status.fed_ml = done ? n_quot : '0;
endmodule

// File: design/queued_pulse_train_doser_core.sv
// ----------------------------------------------------------------------------
// queued_pulse_train_doser_core: dosing pulse generator with a request ring
// Latency: a result is valid in the cycle after its request is accepted.
// Throughput: one request per cycle; the result register is the only stage,
// so a request is taken whenever that register is empty or being drained.
// Reset: synchronous, active low; pointers, job count, drive state, totals and
// configuration registers return to defaults. Ring contents are not cleared.
// ----------------------------------------------------------------------------
module queued_pulse_train_doser_core
    import qptd_pkg::*;
#(
    parameter int RING_DEPTH    = RING_DEPTH_DEF,
    parameter int PULSES_PER_ML = PULSES_PER_ML_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    qptd_req_if.sink             i_req,
    qptd_res_if.source           o_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);
    localparam int IDX_W = $clog2(RING_DEPTH);
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RING_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(RING_DEPTH);

    // Configuration registers. Writes must arrive only while the block is idle; the block does not enforce it.
    logic [TICKS_W-1:0] r_high_ticks;
    logic [TICKS_W-1:0] r_low_ticks;
    logic [MAXP_W-1:0]  r_max_pulses;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_ticks <= HIGH_TICKS_RST;
            r_low_ticks  <= LOW_TICKS_RST;
            r_max_pulses <= MAX_PULSES_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_HIGH_TICKS: r_high_ticks <= i_cfg_data;
                CFG_LOW_TICKS:  r_low_ticks  <= i_cfg_data;
                CFG_MAX_PULSES: r_max_pulses <= i_cfg_data[MAXP_W-1:0];
                default: ;
            endcase
        end
    end

    // Request handshake. A new request is taken whenever the result register
    // is free, or is handing its result over in this same cycle.
    logic r_res_valid;
    logic accept;
    logic is_feed;
    logic is_tick;

    assign i_req.ready = !r_res_valid || o_res.ready;
    assign accept      = i_req.valid && i_req.ready;
    assign is_feed     = accept && (i_req.op == OP_FEED);
    assign is_tick     = accept && (i_req.op == OP_TICK);

    // Ring bookkeeping. The ring memory is read at the head pointer every
    // cycle; its registered output always holds the head target by the time
    // a job first compares its pulse count, because a job starts on a tick
    // after its entry was written, and first compares on a later tick.
    logic [IDX_W-1:0]    r_head, n_head;
    logic [IDX_W-1:0]    r_tail, n_tail;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                ring_full;
    logic                ring_we;
    logic [TARGET_W-1:0] scaled_target;
    logic [TARGET_W-1:0] head_target;
    t_drive_out          drive_st;

    assign ring_full     = (r_count == CNT_FULL);
    assign ring_we       = is_feed && !ring_full;
    assign scaled_target = TARGET_W'(TARGET_W'(i_req.amount_ml) * TARGET_W'(PULSES_PER_ML));

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (ring_we) begin
            n_tail  = (r_tail == IDX_LAST) ? '0 : r_tail + 1'b1;
            n_count = r_count + 1'b1;
        end else if (drive_st.done) begin
            // A finished job always has an entry at the head to retire.
            n_head  = (r_head == IDX_LAST) ? '0 : r_head + 1'b1;
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    qptd_ram #(
        .WIDTH (TARGET_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (r_tail),
        .i_wdata (scaled_target),
        .i_raddr (r_head),
        .o_rdata (head_target)
    );

    // Pulse drive: phase timer, pulse counting and the fed total.
    qptd_drive #(
        .PULSES_PER_ML (PULSES_PER_ML)
    ) u_drive (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick       (is_tick),
        .i_ring_busy  (r_count != '0),
        .i_target     (head_target),
        .i_high_ticks (r_high_ticks),
        .i_low_ticks  (r_low_ticks),
        .i_max_pulses (r_max_pulses),
        .o_status     (drive_st)
    );

    // Result register. The job count is reported through its low bits only,
    // so it is sized to the field width on the way in.
    logic               r_drive_level;
    logic               r_accepted;
    logic               r_rejected;
    logic               r_done;
    logic [FED_W-1:0]   r_fed;
    logic [QJOBS_W-1:0] r_qjobs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (accept) begin
            r_res_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_drive_level <= drive_st.pin;
            r_accepted    <= ring_we;
            r_rejected    <= is_feed && ring_full;
            r_done        <= drive_st.done;
            r_fed         <= drive_st.fed_ml;
            r_qjobs       <= QJOBS_W'(n_count);
        end
    end

    assign o_res.valid            = r_res_valid;
    assign o_res.drive_level      = r_drive_level;
    assign o_res.request_accepted = r_accepted;
    assign o_res.request_rejected = r_rejected;
    assign o_res.job_done         = r_done;
    assign o_res.fed_total_ml     = r_fed;
    assign o_res.queued_jobs      = r_qjobs;
endmodule

// File: verif/queued_pulse_train_doser_core_test.sv
// ----------------------------------------------------------------------------
// queued_pulse_train_doser_core_test: self-checking bench for the pulse doser
// Feeds tick and feed requests through the request channel with random gaps,
// stalls the result channel at random, and predicts every result from a local
// copy of the ring, drive state and registers. Each result is compared field
// by field. The run covers several register settings, the extremes included.
// ----------------------------------------------------------------------------
module queued_pulse_train_doser_core_test;
    import qptd_pkg::*;

    localparam int RING          = RING_DEPTH_DEF;
    localparam int RING_IDX_W    = $clog2(RING);
    localparam int PULSE_SCALE   = PULSES_PER_ML_DEF;
    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int PRINT_CAP     = 60;

    // The index port is two bits wide, so one index addresses no register.
    localparam logic [CFG_IDX_W-1:0]  CFG_SPARE_IDX = 2'd3;
    localparam logic [TIMER_W-1:0]    TIMER_TOP     = '1;
    localparam logic [RING_IDX_W-1:0] RING_LAST     = RING_IDX_W'(RING - 1);

    typedef struct packed {
        logic                op;
        logic [AMOUNT_W-1:0] amount_ml;
    } t_dose_cmd;

    typedef struct packed {
        logic               pin;
        logic               accepted;
        logic               rejected;
        logic               done;
        logic [FED_W-1:0]   fed_ml;
        logic [QJOBS_W-1:0] queued;
    } t_dose_report;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    qptd_req_if req_ch ();
    qptd_res_if res_ch ();

    queued_pulse_train_doser_core #(
        .RING_DEPTH    (RING),
        .PULSES_PER_ML (PULSE_SCALE)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .o_res       (res_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Requests waiting to be driven, and the results that accepted requests
    // have made due. A request counts as outstanding from the moment it is
    // queued until its result has been taken, which gives a race-free test
    // for an idle block at a falling edge.
    t_dose_cmd    feed_tick_backlog[$];
    t_dose_report dose_reports_due[$];
    int           outstanding_cmds = 0;

    // Local copy of the doser: ring of pulse targets, drive state, totals.
    logic [TARGET_W-1:0]   ring_target [RING];
    logic [RING_IDX_W-1:0] ring_head;
    logic [RING_IDX_W-1:0] ring_tail;
    int unsigned           jobs_waiting;
    logic                  feeding;
    logic                  pin_high;
    logic [TARGET_W-1:0]   pulses_in_job;
    logic [TIMER_W-1:0]    phase_ticks;
    logic [TOTAL_W-1:0]    pulses_total;

    // Local copy of the registers.
    logic [TICKS_W-1:0] high_limit;
    logic [TICKS_W-1:0] low_limit;
    logic [MAXP_W-1:0]  pulse_cap;

    // Handshake flags and idling state of both sides.
    logic req_taken = 1'b0;
    logic res_taken = 1'b0;
    int   send_gap = 0;
    bit   send_calm = 1'b0;
    int   take_stall = 0;
    bit   take_calm = 1'b0;
    int   quiet_cycles = 0;

    int mismatch_count = 0;
    int requests_sent  = 0;
    int jobs_finished  = 0;
    int feeds_refused  = 0;
    int settings_used  = 0;

    function automatic void reset_dosing_state();
        foreach (ring_target[i]) ring_target[i] = '0;
        ring_head     = '0;
        ring_tail     = '0;
        jobs_waiting  = 0;
        feeding       = 1'b0;
        pin_high      = 1'b0;
        pulses_in_job = '0;
        phase_ticks   = '0;
        pulses_total  = '0;
        high_limit    = HIGH_TICKS_RST;
        low_limit     = LOW_TICKS_RST;
        pulse_cap     = MAX_PULSES_RST;
    endfunction

    // Applies one request to the local copy and returns what the block must
    // report for it. A feed only touches the ring; a tick moves the drive.
    function automatic t_dose_report advance_dosing(t_dose_cmd cmd);
        t_dose_report rep;
        rep = '0;
        if (cmd.op == OP_FEED) begin
            if (jobs_waiting < RING) begin
                ring_target[ring_tail] = TARGET_W'(cmd.amount_ml * PULSE_SCALE);
                ring_tail = (ring_tail == RING_LAST) ? '0 : ring_tail + 1'b1;
                jobs_waiting++;
                rep.accepted = 1'b1;
            end else begin
                rep.rejected = 1'b1;
            end
        end else if (feeding) begin
            if (phase_ticks != TIMER_TOP) phase_ticks++;
            if (!pin_high) begin
                if (phase_ticks > TIMER_W'(low_limit)) begin
                    // Every end of a low phase is one pulse; the job closes
                    // once its count passes the target or the safety cap.
                    pulses_total++;
                    pulses_in_job++;
                    if (pulses_in_job > ring_target[ring_head] ||
                        pulses_in_job > TARGET_W'(pulse_cap)) begin
                        feeding   = 1'b0;
                        ring_head = (ring_head == RING_LAST) ? '0 : ring_head + 1'b1;
                        if (jobs_waiting > 0) jobs_waiting--;
                        rep.done   = 1'b1;
                        rep.fed_ml = FED_W'(pulses_total / TOTAL_W'(PULSE_SCALE));
                    end else begin
                        pin_high    = 1'b1;
                        phase_ticks = '0;
                    end
                end
            end else if (phase_ticks > TIMER_W'(high_limit)) begin
                pin_high    = 1'b0;
                phase_ticks = '0;
            end
        end else if (jobs_waiting > 0) begin
            // A new job always opens with the pin low and a fresh count.
            feeding       = 1'b1;
            pulses_in_job = '0;
            pin_high      = 1'b0;
            phase_ticks   = '0;
        end
        rep.pin    = pin_high;
        rep.queued = QJOBS_W'(jobs_waiting);
        return rep;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP) $display("MISMATCH @%0t: %s", $time, what);
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    task automatic enqueue_cmd(input logic op, input logic [AMOUNT_W-1:0] amount);
        t_dose_cmd cmd;
        cmd.op        = op;
        cmd.amount_ml = amount;
        feed_tick_backlog.push_back(cmd);
        outstanding_cmds++;
    endtask

    // Mostly tiny amounts so that jobs finish inside a phase; now and then
    // any amount at all, which exercises every bit and the safety cap.
    function automatic logic [AMOUNT_W-1:0] pick_amount(input int big_pct);
        if ($urandom_range(0, 99) < big_pct) return AMOUNT_W'($urandom_range(0, 1023));
        return AMOUNT_W'($urandom_range(0, 2));
    endfunction

    // Returns at a falling edge once nothing is queued, in flight or due.
    task automatic wait_until_drained();
        do @(negedge i_clk);
        while (outstanding_cmds != 0);
    endtask

    // Leaves the write enable high, so several writes can follow back to back
    // with exactly one assignment of the enable per time step.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        case (idx)
            CFG_HIGH_TICKS: high_limit = value[TICKS_W-1:0];
            CFG_LOW_TICKS:  low_limit  = value[TICKS_W-1:0];
            CFG_MAX_PULSES: pulse_cap  = value[MAXP_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic apply_settings(input logic [CFG_W-1:0] high, input logic [CFG_W-1:0] low,
                                  input logic [CFG_W-1:0] cap);
        write_register(CFG_HIGH_TICKS, high);
        write_register(CFG_LOW_TICKS, low);
        write_register(CFG_MAX_PULSES, cap);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Mostly ticks so that queued jobs run to their end, with single feeds
    // and short bursts of feeds that push the ring to full and beyond.
    task automatic queue_random_stretch(input int count, input int big_pct);
        int made;
        int roll;
        int burst;
        made = 0;
        while (made < count) begin
            roll = $urandom_range(0, 99);
            if (roll < 2) begin
                burst = $urandom_range(3, 9);
                repeat (burst) enqueue_cmd(OP_FEED, pick_amount(big_pct));
                made += burst;
            end else if (roll < 9) begin
                enqueue_cmd(OP_FEED, pick_amount(big_pct));
                made++;
            end else begin
                // The amount rides along on ticks too and must be ignored.
                enqueue_cmd(OP_TICK, AMOUNT_W'($urandom_range(0, 1023)));
                made++;
            end
        end
    endtask

    // Registers change only while the block is idle, so each phase first
    // holds the sender until every result of the last phase has come back.
    task automatic run_phase(input logic [CFG_W-1:0] high, input logic [CFG_W-1:0] low,
                             input logic [CFG_W-1:0] cap, input int count,
                             input int big_pct);
        wait_until_drained();
        apply_settings(high, low, cap);
        queue_random_stretch(count, big_pct);
    endtask

    // Request driver: a new request goes out at a falling edge once the last
    // one was taken and the drawn gap has run out. A calm stretch sends back
    // to back.
    always @(negedge i_clk) begin
        t_dose_cmd nxt;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (!req_ch.valid || req_taken) begin
            if (send_gap > 0) begin
                send_gap     <= send_gap - 1;
                req_ch.valid <= 1'b0;
            end else if (feed_tick_backlog.size() != 0) begin
                nxt = feed_tick_backlog.pop_front();
                req_ch.op        <= nxt.op;
                req_ch.amount_ml <= nxt.amount_ml;
                req_ch.valid     <= 1'b1;
                if ($urandom_range(0, 15) == 0) send_calm = !send_calm;
                send_gap <= send_calm ? 0 : $urandom_range(0, 9);
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Result receiver: after each taken result it draws a stall, which runs
    // down only while a result is actually offered.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_taken) begin
                if ($urandom_range(0, 15) == 0) take_calm = !take_calm;
                take_stall = take_calm ? 0 : $urandom_range(0, 9);
            end
            if (take_stall > 0) begin
                res_ch.ready <= 1'b0;
                if (res_ch.valid) take_stall--;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // Monitor: at each rising edge a taken result is checked against the
    // oldest one due, and a taken request makes its own result due.
    always @(posedge i_clk) begin
        t_dose_report seen;
        t_dose_report want;
        req_taken <= req_ch.valid && req_ch.ready;
        res_taken <= res_ch.valid && res_ch.ready;
        if (i_rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                seen.pin      = res_ch.drive_level;
                seen.accepted = res_ch.request_accepted;
                seen.rejected = res_ch.request_rejected;
                seen.done     = res_ch.job_done;
                seen.fed_ml   = res_ch.fed_total_ml;
                seen.queued   = res_ch.queued_jobs;
                if (dose_reports_due.size() == 0) begin
                    report_mismatch("result taken while no request was waiting on one");
                end else begin
                    want = dose_reports_due.pop_front();
                    compare_field("drive_level", 32'(seen.pin), 32'(want.pin));
                    compare_field("request_accepted", 32'(seen.accepted),
                                  32'(want.accepted));
                    compare_field("request_rejected", 32'(seen.rejected),
                                  32'(want.rejected));
                    compare_field("job_done", 32'(seen.done), 32'(want.done));
                    compare_field("fed_total_ml", 32'(seen.fed_ml), 32'(want.fed_ml));
                    compare_field("queued_jobs", 32'(seen.queued), 32'(want.queued));
                    if (want.done) jobs_finished++;
                    if (want.rejected) feeds_refused++;
                    if (outstanding_cmds > 0) outstanding_cmds--;
                end
            end
            if (req_ch.valid && req_ch.ready) begin
                dose_reports_due.push_back(advance_dosing({req_ch.op, req_ch.amount_ml}));
                requests_sent++;
            end
        end
    end

    // Watchdog: too long without any handshake means the block has hung.
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("watchdog: %0d cycles without a handshake, %0d results still due",
                     quiet_cycles, outstanding_cmds);
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_index      = CFG_HIGH_TICKS;
        i_cfg_data       = '0;
        req_ch.valid     = 1'b0;
        req_ch.op        = OP_TICK;
        req_ch.amount_ml = '0;
        res_ch.ready     = 1'b0;
        reset_dosing_state();
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset timing: a zero amount and the largest amount are queued, and
        // the first job starts, but no low phase can end this early.
        enqueue_cmd(OP_FEED, '0);
        enqueue_cmd(OP_TICK, '1);
        enqueue_cmd(OP_TICK, '0);
        enqueue_cmd(OP_FEED, '1);
        enqueue_cmd(OP_TICK, '0);
        wait_until_drained();

        // Zero timing and a zero cap, the cap written with its unused upper
        // bits set. A write to the spare index must change nothing.
        write_register(CFG_SPARE_IDX, 16'hFFFF);
        apply_settings(16'h0000, 16'h0000, 16'hFC00);

        // The running job ends at once, the large job starts on the next
        // tick and ends after its single pulse; then idle ticks on an empty
        // ring.
        repeat (5) enqueue_cmd(OP_TICK, '0);

        // Nine feeds against eight slots: the last one finds the ring full.
        enqueue_cmd(OP_FEED, 10'd1);
        enqueue_cmd(OP_FEED, 10'd2);
        enqueue_cmd(OP_FEED, 10'h200);
        enqueue_cmd(OP_FEED, 10'h155);
        enqueue_cmd(OP_FEED, 10'h2AA);
        enqueue_cmd(OP_FEED, 10'd3);
        enqueue_cmd(OP_FEED, 10'd0);
        enqueue_cmd(OP_FEED, '1);
        enqueue_cmd(OP_FEED, 10'd5);
        repeat (4) enqueue_cmd(OP_TICK, '0);

        // Random stretches under a spread of settings. The wide cap lets the
        // job target decide the pulse count; the widest timing ends the run
        // in the middle of one phase.
        run_phase(16'd1, 16'd2, 16'd5, 150, 20);
        run_phase(16'd0, 16'd3, 16'd1023, 150, 3);
        run_phase(16'd3, 16'd0, 16'd12, 150, 20);
        run_phase(CFG_W'($urandom_range(0, 4)), CFG_W'($urandom_range(0, 4)),
                  CFG_W'($urandom_range(0, 15)), 150, 20);
        run_phase(16'hFFFF, 16'hFFFF, 16'h03FF, 40, 20);
        run_phase(16'd1, 16'd1, 16'd3, 60, 20);

        wait_until_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (dose_reports_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", dose_reports_due.size()));

        $display("covered %0d requests under %0d register settings", requests_sent,
                 settings_used);
        $display("%0d jobs ran to their end, %0d feeds found the ring full", jobs_finished,
                 feeds_refused);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
